[src/irclt_pkg.sv]
// Shared types, codes and helpers for the IRC line tokenizer.
package irclt_pkg;

  localparam int CFG_LEN_W   = 13;
  localparam int CFG_PARAM_W = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PARAMS      = 1'b1;

  localparam logic [CFG_LEN_W-1:0]   MAX_LINE_LENGTH_RST = 13'd4096;
  localparam logic [CFG_PARAM_W-1:0] MAX_PARAMS_RST      = 4'd15;
  localparam logic [3:0]             PARAM_COUNT_SAT     = 4'd15;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    FS_IDLE   = 2'd0,
    FS_INLINE = 2'd1,
    FS_WAITLF = 2'd2,
    FS_ERROR  = 2'd3
  } frame_state_t;

  typedef enum logic [2:0] {
    ROLE_START  = 3'd0,
    ROLE_PREFIX = 3'd1,
    ROLE_CMD    = 3'd2,
    ROLE_PARAM  = 3'd3,
    ROLE_TRAIL  = 3'd4
  } role_t;

  typedef enum logic [2:0] {
    CK_EMPTY = 3'd0,
    CK_ALPHA = 3'd1,
    CK_D1    = 3'd2,
    CK_D2    = 3'd3,
    CK_D3    = 3'd4,
    CK_BAD   = 3'd5
  } cmd_kind_t;

  typedef enum logic [2:0] {
    TC_DELIM   = 3'd0,
    TC_PREFIX  = 3'd1,
    TC_COMMAND = 3'd2,
    TC_MIDDLE  = 3'd3,
    TC_TRAIL   = 3'd4
  } token_class_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_STRAY_TERM   = 3'd1,
    ERR_NO_LF        = 3'd2,
    ERR_TOO_LONG     = 3'd3,
    ERR_EMPTY_WORD   = 3'd4,
    ERR_EMPTY_PREFIX = 3'd5,
    ERR_BAD_COMMAND  = 3'd6,
    ERR_STUCK        = 3'd7
  } err_t;

  typedef struct packed {
    role_t      role;
    logic       word_empty;
    logic [3:0] param_count;
    cmd_kind_t  cmd_kind;
    err_t       fault;
  } line_state_t;

  typedef struct packed {
    token_class_t cls;
    logic [3:0]   idx;
    logic         done;
    logic         ok;
    err_t         err;
  } result_t;

  localparam line_state_t LINE_CLEAR = '{
    role:        ROLE_START,
    word_empty:  1'b1,
    param_count: 4'd0,
    cmd_kind:    CK_EMPTY,
    fault:       ERR_NONE
  };

  function automatic err_t note_fault(input err_t cur, input err_t code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

endpackage

[src/irclt_core.sv]
// Combinational per-byte state update and classification for the tokenizer.
module irclt_core #(
  parameter int LINE_LIMIT_MAX  = 4096,
  parameter int PARAM_LIMIT_MAX = 15,
  parameter int LEN_W           = 13
) (
  input  logic [7:0]                        byte_value,
  input  irclt_pkg::frame_state_t           frame_st,
  input  irclt_pkg::line_state_t            line_st,
  input  logic [LEN_W-1:0]                  line_len,
  input  logic [irclt_pkg::CFG_LEN_W-1:0]   max_line_length,
  input  logic [irclt_pkg::CFG_PARAM_W-1:0] max_params,
  output irclt_pkg::frame_state_t           frame_nxt,
  output irclt_pkg::line_state_t            line_nxt,
  output logic [LEN_W-1:0]                  len_nxt,
  output irclt_pkg::result_t                res
);
  import irclt_pkg::*;

  localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

  logic          is_cr, is_lf, is_term;
  line_state_t   base;
  logic [LEN_W-1:0] base_len;
  logic [CMP_W-1:0] cfg_ext, llm, lim;
  logic          overflow;
  logic [3:0]    plm, eff_params, idx_last;
  line_state_t   tok_st;
  token_class_t  tok_cls;
  logic [3:0]    tok_idx;
  err_t          end_fault;

  function automatic cmd_kind_t feed_command(input cmd_kind_t k, input logic [7:0] b);
    logic alpha, digit;
    alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    digit = (b >= 8'h30 && b <= 8'h39);
    if (alpha) begin
      return (k == CK_EMPTY || k == CK_ALPHA) ? CK_ALPHA : CK_BAD;
    end else if (digit) begin
      case (k)
        CK_EMPTY: return CK_D1;
        CK_D1:    return CK_D2;
        CK_D2:    return CK_D3;
        default:  return CK_BAD;
      endcase
    end
    return CK_BAD;
  endfunction

  assign is_cr   = (byte_value == CH_CR);
  assign is_lf   = (byte_value == CH_LF);
  assign is_term = is_cr || is_lf;

  // A new line starts from cleared state when the first byte arrives in idle
  assign base     = (frame_st == FS_IDLE) ? LINE_CLEAR : line_st;
  assign base_len = (frame_st == FS_IDLE) ? '0 : line_len;

  assign cfg_ext  = CMP_W'(max_line_length);
  assign llm      = CMP_W'(LINE_LIMIT_MAX);
  assign lim      = (cfg_ext == '0) ? CMP_W'(1) : ((cfg_ext > llm) ? llm : cfg_ext);
  assign overflow = (CMP_W'(base_len) >= lim);

  assign plm        = 4'(PARAM_LIMIT_MAX);
  assign eff_params = (max_params == '0) ? 4'd1 : ((max_params > plm) ? plm : max_params);
  assign idx_last   = (base.param_count != 4'd0) ? base.param_count - 4'd1 : 4'd0;

  // Classify one in-line byte
  always_comb begin
    tok_st  = base;
    tok_cls = TC_DELIM;
    tok_idx = 4'd0;
    if (byte_value == CH_SPACE && base.role != ROLE_TRAIL) begin
      case (base.role)
        ROLE_START: tok_st.fault = note_fault(base.fault, ERR_EMPTY_WORD);
        ROLE_PREFIX: begin
          if (base.word_empty) tok_st.fault = note_fault(base.fault, ERR_EMPTY_PREFIX);
          tok_st.role       = ROLE_CMD;
          tok_st.word_empty = 1'b1;
        end
        ROLE_CMD: begin
          if (base.word_empty) begin
            tok_st.fault = note_fault(base.fault, ERR_EMPTY_WORD);
          end else begin
            tok_st.role       = ROLE_PARAM;
            tok_st.word_empty = 1'b1;
          end
        end
        ROLE_PARAM: begin
          if (base.word_empty) begin
            tok_st.fault = note_fault(base.fault, ERR_EMPTY_WORD);
          end else if (base.param_count >= eff_params) begin
            tok_st.role = ROLE_TRAIL;
            tok_cls     = TC_TRAIL;
            tok_idx     = idx_last;
          end else begin
            tok_st.word_empty = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (base.role)
        ROLE_START: begin
          if (byte_value == CH_COLON) begin
            tok_st.role       = ROLE_PREFIX;
            tok_st.word_empty = 1'b1;
            tok_cls           = TC_PREFIX;
          end else begin
            tok_st.role       = ROLE_CMD;
            tok_st.word_empty = 1'b0;
            tok_st.cmd_kind   = feed_command(base.cmd_kind, byte_value);
            tok_cls           = TC_COMMAND;
          end
        end
        ROLE_PREFIX: begin
          tok_st.word_empty = 1'b0;
          tok_cls           = TC_PREFIX;
        end
        ROLE_CMD: begin
          tok_st.word_empty = 1'b0;
          tok_st.cmd_kind   = feed_command(base.cmd_kind, byte_value);
          tok_cls           = TC_COMMAND;
        end
        ROLE_PARAM: begin
          if (base.word_empty) begin
            tok_idx            = base.param_count;
            tok_st.param_count = (base.param_count != PARAM_COUNT_SAT) ?
                                 base.param_count + 4'd1 : base.param_count;
            tok_st.word_empty  = 1'b0;
            if (byte_value == CH_COLON) begin
              tok_st.role = ROLE_TRAIL;
              tok_cls     = TC_TRAIL;
            end else begin
              tok_cls = TC_MIDDLE;
            end
          end else begin
            tok_idx = idx_last;
            tok_cls = TC_MIDDLE;
          end
        end
        default: begin
          tok_cls = TC_TRAIL;
          tok_idx = idx_last;
        end
      endcase
    end
  end

  // Verdict at the terminator: close the last word, then check the command
  always_comb begin
    end_fault = base.fault;
    case (base.role)
      ROLE_START:  end_fault = note_fault(base.fault, ERR_EMPTY_WORD);
      ROLE_PREFIX: if (base.word_empty) end_fault = note_fault(base.fault, ERR_EMPTY_PREFIX);
      ROLE_CMD:    if (base.word_empty) end_fault = note_fault(base.fault, ERR_EMPTY_WORD);
      ROLE_PARAM:  if (base.word_empty) end_fault = note_fault(base.fault, ERR_EMPTY_WORD);
      default: ;
    endcase
    if (base.cmd_kind != CK_ALPHA && base.cmd_kind != CK_D3)
      end_fault = note_fault(end_fault, ERR_BAD_COMMAND);
  end

  // Frame next state
  always_comb begin
    frame_nxt = frame_st;
    unique case (frame_st) inside
      FS_ERROR:  frame_nxt = FS_ERROR;
      FS_WAITLF: frame_nxt = is_lf ? FS_IDLE : FS_ERROR;
      FS_IDLE, FS_INLINE: begin
        if (is_term) begin
          if (frame_st == FS_IDLE || end_fault != ERR_NONE) frame_nxt = FS_ERROR;
          else frame_nxt = is_cr ? FS_WAITLF : FS_IDLE;
        end else begin
          frame_nxt = overflow ? FS_ERROR : FS_INLINE;
        end
      end
    endcase
  end

  // Result and line state
  always_comb begin
    res      = '{cls: TC_DELIM, idx: 4'd0, done: 1'b0, ok: 1'b0, err: ERR_NONE};
    line_nxt = line_st;
    len_nxt  = line_len;
    unique case (frame_st) inside
      FS_ERROR:  res.err = ERR_STUCK;
      FS_WAITLF: if (!is_lf) res.err = ERR_NO_LF;
      FS_IDLE, FS_INLINE: begin
        if (is_term && frame_st == FS_IDLE) begin
          res.done = 1'b1;
          res.err  = ERR_STRAY_TERM;
        end else if (is_term) begin
          res.done = 1'b1;
          res.err  = end_fault;
          res.ok   = (end_fault == ERR_NONE);
          line_nxt = LINE_CLEAR;
          len_nxt  = '0;
        end else if (overflow) begin
          res.err = ERR_TOO_LONG;
        end else begin
          len_nxt  = base_len + LEN_W'(1);
          line_nxt = tok_st;
          res.cls  = tok_cls;
          res.idx  = tok_idx;
        end
      end
    endcase
  end

endmodule

[src/irc_line_tokenizer.sv]
// Top level of the IRC line tokenizer: handshake, state and config registers.
// Each item passes through the input register, then the result register.
// Throughput: one byte per cycle while out_stall is low; the line state update loop sets it.
// An input register and a result register let the next item enter while a result waits.
// Reset (rst_n low, synchronous) empties both stages, returns framing to idle,
// clears the line state and loads max_line_length 4096 and max_params 15.
module irc_line_tokenizer #(
  parameter int LINE_LIMIT_MAX  = 4096,
  parameter int PARAM_LIMIT_MAX = 15
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte_echo,
  output logic [2:0]                       out_token_class,
  output logic [3:0]                       out_param_index,
  output logic                             out_line_done,
  output logic                             out_line_ok,
  output logic [2:0]                       out_error_code,
  // configuration port
  input  logic                             cfg_we,
  input  logic [irclt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irclt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import irclt_pkg::*;

  // line_length never exceeds the largest allowed limit
  localparam int LEN_W = $clog2(LINE_LIMIT_MAX + 1);

  // input stage
  logic             s1_vld_r, s1_vld_nxt;
  logic [7:0]       s1_byte_r;
  // result stage
  logic             out_vld_r, out_vld_nxt;
  logic [7:0]       out_byte_r;
  result_t          res_r;
  // tokenizer state
  frame_state_t     frame_r, frame_nxt;
  line_state_t      line_r, line_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  result_t          res_nxt;
  // configuration
  logic [CFG_LEN_W-1:0]   max_len_r;
  logic [CFG_PARAM_W-1:0] max_params_r;

  logic in_take;
  logic advance;

  // Advance the input item into the result register when that register is
  // empty or being drained this cycle; the state update rides on the same edge.
  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_take) s1_vld_nxt = 1'b1;
    else if (advance) s1_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) out_vld_nxt = 1'b1;
    else if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
  end

  irclt_core #(
    .LINE_LIMIT_MAX  (LINE_LIMIT_MAX),
    .PARAM_LIMIT_MAX (PARAM_LIMIT_MAX),
    .LEN_W           (LEN_W)
  ) u_core (
    .byte_value      (s1_byte_r),
    .frame_st        (frame_r),
    .line_st         (line_r),
    .line_len        (len_r),
    .max_line_length (max_len_r),
    .max_params      (max_params_r),
    .frame_nxt       (frame_nxt),
    .line_nxt        (line_nxt),
    .len_nxt         (len_nxt),
    .res             (res_nxt)
  );

  // Handshake and tokenizer control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      frame_r   <= FS_IDLE;
      line_r    <= LINE_CLEAR;
      len_r     <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        frame_r <= frame_nxt;
        line_r  <= line_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) s1_byte_r <= in_byte_value;
    if (advance) begin
      out_byte_r <= s1_byte_r;
      res_r      <= res_nxt;
    end
  end

  // Configuration writes; the register width drops the upper data bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_LINE_LENGTH_RST;
      max_params_r <= MAX_PARAMS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LINE_LENGTH: max_len_r    <= cfg_wdata[CFG_LEN_W-1:0];
        REG_MAX_PARAMS:      max_params_r <= cfg_wdata[CFG_PARAM_W-1:0];
      endcase
    end
  end

  assign out_valid       = out_vld_r;
  assign out_byte_echo   = out_byte_r;
  assign out_token_class = res_r.cls;
  assign out_param_index = res_r.idx;
  assign out_line_done   = res_r.done;
  assign out_line_ok     = res_r.ok;
  assign out_error_code  = res_r.err;

endmodule

[bench/tb_irc_line_tokenizer.sv]
// Self-checking testbench for irc_line_tokenizer: byte stream in, tagged bytes and verdicts out.
module tb_irc_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import irclt_pkg::*;

  // Caps handed to the block, and the saturation points of the predictor.
  localparam int LINE_CAP  = 4096;
  localparam int PARAM_CAP = 15;

  // Long receiver hold-off, long enough to fill both internal stages.
  localparam int HOLD_CYCLES = 40;

  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_Z_UP = 8'h5A;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_Z_LO = 8'h7A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Opening lines: prefix with the byte extremes, numeric command, middle and
  // trailing parameters, CR LF; then a letters-only command ended by a bare LF.
  localparam logic [7:0] OPENING_BYTES [0:19] = '{
    CH_COLON, 8'hFF, 8'h00, CH_SPACE,
    CH_ZERO, CH_ZERO, 8'h31, CH_SPACE,
    8'h61, 8'h80, CH_SPACE,
    CH_COLON, 8'h62, CH_SPACE, 8'h63, CH_CR, CH_LF,
    CH_Z_UP, CH_Z_LO, CH_LF
  };

  // Ways to break a line once, near the end of the run (the error is sticky).
  typedef enum {
    FK_EMPTY_LINE,
    FK_NO_LF,
    FK_OVERFLOW,
    FK_EMPTY_WORD,
    FK_EMPTY_PREFIX,
    FK_BAD_COMMAND
  } fault_kind_t;

  // One tagged byte as it leaves the block.
  typedef struct packed {
    logic [7:0]   byte_echo;
    token_class_t cls;
    logic [3:0]   idx;
    logic         done;
    logic         ok;
    err_t         err;
  } token_t;

  // Tracks the framing and word state of the line, predicts the tagged byte
  // for each accepted input byte and holds the predictions until they come.
  class line_tracker;
    frame_state_t frame;
    int unsigned  line_len;
    role_t        role;
    bit           word_empty;
    logic [3:0]   params_seen;
    cmd_kind_t    cmd;
    err_t         fault;
    logic [12:0]  len_reg;
    logic [3:0]   param_reg;
    token_t       pending_tokens[$];
    int           failures;

    function new();
      len_reg   = MAX_LINE_LENGTH_RST;
      param_reg = MAX_PARAMS_RST;
      frame     = FS_IDLE;
      failures  = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len    = 0;
      role        = ROLE_START;
      word_empty  = 1'b1;
      params_seen = 4'd0;
      cmd         = CK_EMPTY;
      fault       = ERR_NONE;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MAX_LINE_LENGTH: len_reg = val[CFG_LEN_W-1:0];
        REG_MAX_PARAMS:      param_reg = val[CFG_PARAM_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned line_limit();
      if (len_reg == 0) return 1;
      if (len_reg > LINE_CAP) return LINE_CAP;
      return len_reg;
    endfunction

    function int unsigned param_limit();
      if (param_reg == 0) return 1;
      if (param_reg > PARAM_CAP) return PARAM_CAP;
      return param_reg;
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction

    // Only the first fault of a line is kept.
    function void flag(err_t code);
      if (fault == ERR_NONE) fault = code;
    endfunction

    function logic [3:0] last_index();
      return (params_seen != 0) ? params_seen - 4'd1 : 4'd0;
    endfunction

    function void feed_command(logic [7:0] b);
      bit alpha, digit;
      alpha = (b >= CH_A_UP && b <= CH_Z_UP) || (b >= CH_A_LO && b <= CH_Z_LO);
      digit = (b >= CH_ZERO && b <= CH_NINE);
      if (alpha) begin
        cmd = (cmd == CK_EMPTY || cmd == CK_ALPHA) ? CK_ALPHA : CK_BAD;
      end else if (digit) begin
        case (cmd)
          CK_EMPTY: cmd = CK_D1;
          CK_D1:    cmd = CK_D2;
          CK_D2:    cmd = CK_D3;
          default:  cmd = CK_BAD;
        endcase
      end else begin
        cmd = CK_BAD;
      end
    endfunction

    // Close the current word at a space, or at the line end when last is set.
    function void close_word(bit last, inout token_class_t cls, inout logic [3:0] idx);
      case (role)
        ROLE_START: flag(ERR_EMPTY_WORD);
        ROLE_PREFIX: begin
          if (word_empty) flag(ERR_EMPTY_PREFIX);
          if (!last) begin
            role       = ROLE_CMD;
            word_empty = 1'b1;
          end
        end
        ROLE_CMD: begin
          if (word_empty) flag(ERR_EMPTY_WORD);
          else if (!last) begin
            role       = ROLE_PARAM;
            word_empty = 1'b1;
          end
        end
        ROLE_PARAM: begin
          if (word_empty) flag(ERR_EMPTY_WORD);
          else if (!last) begin
            if (params_seen >= param_limit()) begin
              role = ROLE_TRAIL;
              cls  = TC_TRAIL;
              idx  = last_index();
            end else begin
              word_empty = 1'b1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void classify(logic [7:0] b, inout token_class_t cls, inout logic [3:0] idx);
      cls = TC_DELIM;
      idx = 4'd0;
      if (b == CH_SPACE && role != ROLE_TRAIL) begin
        close_word(1'b0, cls, idx);
        return;
      end
      case (role)
        ROLE_START: begin
          if (b == CH_COLON) begin
            role       = ROLE_PREFIX;
            word_empty = 1'b1;
            cls        = TC_PREFIX;
          end else begin
            role       = ROLE_CMD;
            word_empty = 1'b0;
            feed_command(b);
            cls        = TC_COMMAND;
          end
        end
        ROLE_PREFIX: begin
          word_empty = 1'b0;
          cls        = TC_PREFIX;
        end
        ROLE_CMD: begin
          word_empty = 1'b0;
          feed_command(b);
          cls        = TC_COMMAND;
        end
        ROLE_PARAM: begin
          if (word_empty) begin
            idx = params_seen;
            if (params_seen < PARAM_COUNT_SAT) params_seen = params_seen + 4'd1;
            word_empty = 1'b0;
            if (b == CH_COLON) begin
              role = ROLE_TRAIL;
              cls  = TC_TRAIL;
            end else begin
              cls = TC_MIDDLE;
            end
          end else begin
            idx = last_index();
            cls = TC_MIDDLE;
          end
        end
        default: begin
          cls = TC_TRAIL;
          idx = last_index();
        end
      endcase
    endfunction

    function void accept_byte(logic [7:0] b);
      token_t       t;
      token_class_t spare_cls;
      logic [3:0]   spare_idx;
      bit           term;
      t         = '{b, TC_DELIM, 4'd0, 1'b0, 1'b0, ERR_NONE};
      spare_cls = TC_DELIM;
      spare_idx = 4'd0;
      term      = (b == CH_CR || b == CH_LF);
      case (frame)
        FS_ERROR: t.err = ERR_STUCK;
        FS_WAITLF: begin
          if (b == CH_LF) frame = FS_IDLE;
          else begin
            t.err = ERR_NO_LF;
            frame = FS_ERROR;
          end
        end
        default: begin
          if (frame == FS_IDLE && term) begin
            t.done = 1'b1;
            t.err  = ERR_STRAY_TERM;
            frame  = FS_ERROR;
          end else begin
            if (frame == FS_IDLE) begin
              clear_line();
              frame = FS_INLINE;
            end
            if (term) begin
              close_word(1'b1, spare_cls, spare_idx);
              if (cmd != CK_ALPHA && cmd != CK_D3) flag(ERR_BAD_COMMAND);
              t.done = 1'b1;
              t.err  = fault;
              t.ok   = (fault == ERR_NONE);
              if (!t.ok) frame = FS_ERROR;
              else frame = (b == CH_CR) ? FS_WAITLF : FS_IDLE;
              clear_line();
            end else if (line_len + 1 > line_limit()) begin
              t.err = ERR_TOO_LONG;
              frame = FS_ERROR;
            end else begin
              line_len++;
              classify(b, t.cls, t.idx);
            end
          end
        end
      endcase
      pending_tokens = {pending_tokens, t};
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void match_token(token_t got);
      token_t want;
      if (pending_tokens.size() == 0) begin
        $error("byte %0h came out with no byte outstanding", got.byte_echo);
        failures++;
        return;
      end
      want = pending_tokens.pop_front();
      check_field("byte_echo", want.byte_echo, got.byte_echo);
      check_field("token_class", want.cls, got.cls);
      check_field("param_index", want.idx, got.idx);
      check_field("line_done", want.done, got.done);
      check_field("line_ok", want.ok, got.ok);
      check_field("error_code", want.err, got.err);
    endfunction
  endclass

  // Block inputs start at known values.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [7:0]            in_byte_value = 8'h00;
  logic                  out_stall = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte_echo;
  logic [2:0] out_token_class;
  logic [3:0] out_param_index;
  logic       out_line_done;
  logic       out_line_ok;
  logic [2:0] out_error_code;

  line_tracker tracker = new();
  int unsigned items_sent = 0;
  bit          allow_gaps = 1'b1;   // random idle bursts on both sides
  bit          hold_results = 1'b0; // request one long receiver hold-off

  irc_line_tokenizer #(
    .LINE_LIMIT_MAX  (LINE_CAP),
    .PARAM_LIMIT_MAX (PARAM_CAP)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_echo   (out_byte_echo),
    .out_token_class (out_token_class),
    .out_param_index (out_param_index),
    .out_line_done   (out_line_done),
    .out_line_ok     (out_line_ok),
    .out_error_code  (out_error_code),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Sample the result channel with pre-edge values and match each item taken.
  always @(posedge clk) begin : result_monitor
    token_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.byte_echo = out_byte_echo;
      seen.cls       = token_class_t'(out_token_class);
      seen.idx       = out_param_index;
      seen.done      = out_line_done;
      seen.ok        = out_line_ok;
      seen.err       = err_t'(out_error_code);
      tracker.match_token(seen);
    end
  end

  // Receiver side: short random stalls, or one long hold-off on request.
  initial begin : result_backpressure
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_results = 1'b0;
      end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item, hold it until taken, then note it in the tracker.
  task automatic send_byte(input logic [7:0] b);
    if (allow_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.accept_byte(b);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted item has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; the upper bits of the count word are junk.
  task automatic set_limits(input logic [12:0] len, input logic [3:0] cnt);
    logic [CFG_DATA_W-1:0] count_word;
    count_word = {9'($urandom_range(0, 511)), cnt};
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_LINE_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    tracker.write_reg(REG_MAX_LINE_LENGTH, len);
    cfg_index <= REG_MAX_PARAMS;
    cfg_wdata <= count_word;
    @(posedge clk);
    tracker.write_reg(REG_MAX_PARAMS, count_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] letter();
    return $urandom_range(0, 1) ? 8'(CH_A_UP + $urandom_range(0, 25))
                                : 8'(CH_A_LO + $urandom_range(0, 25));
  endfunction

  // Any byte that may sit inside a word.
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_SPACE || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // Any byte that may sit in the trailing part, spaces weighted up.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) return CH_SPACE;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // Build one well-formed line with random content that fits the current limit.
  task automatic send_message();
    logic [7:0]  msg[$];
    int unsigned n_words;
    int unsigned cap;
    cap = tracker.line_limit();
    if ($urandom_range(0, 2) == 0) begin
      msg = {msg, CH_COLON};
      repeat ($urandom_range(1, 6)) msg = {msg, word_byte()};
      msg = {msg, CH_SPACE};
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat (3) msg = {msg, 8'(CH_ZERO + $urandom_range(0, 9))};
    end else begin
      repeat ($urandom_range(1, 6)) msg = {msg, letter()};
    end
    // Mostly a handful of words; now and then up to 17, past the largest parameter limit.
    n_words = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 17) : $urandom_range(0, 6);
    for (int w = 0; w < n_words; w++) begin
      msg = {msg, CH_SPACE};
      if (w == n_words - 1 && $urandom_range(0, 1) == 1) begin
        msg = {msg, CH_COLON};
        repeat ($urandom_range(0, 10)) msg = {msg, text_byte()};
      end else begin
        repeat ($urandom_range(1, 5)) msg = {msg, word_byte()};
      end
    end
    // Too long for the limit: fall back to a short command alone.
    if (msg.size() > cap) begin
      msg.delete();
      repeat ($urandom_range(1, (cap < 6) ? cap : 6)) msg = {msg, letter()};
    end
    if ($urandom_range(0, 1) == 1) msg = {msg, CH_CR};
    msg = {msg, CH_LF};
    foreach (msg[i]) send_byte(msg[i]);
  endtask

  task automatic send_lines(input int unsigned count);
    int unsigned goal;
    goal = items_sent + count;
    while (items_sent < goal) send_message();
  endtask

  task automatic run_phase(input logic [12:0] len, input logic [3:0] cnt,
                           input int unsigned count);
    drain();
    set_limits(len, cnt);
    send_lines(count);
  endtask

  // Break one line in the chosen way; the block then stays in its error state.
  task automatic break_line(input fault_kind_t kind);
    int unsigned cap;
    cap = tracker.line_limit();
    case (kind)
      FK_EMPTY_LINE: send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      FK_NO_LF: begin
        send_byte(letter());
        send_byte(CH_CR);
        send_byte(word_byte());
      end
      FK_OVERFLOW: begin
        repeat (cap + 1) send_byte(letter());
        send_byte(CH_LF);
      end
      FK_EMPTY_WORD: begin
        if ($urandom_range(0, 1) == 1) begin
          send_byte(CH_SPACE);
          send_byte(letter());
        end else begin
          send_byte(letter());
          send_byte(CH_SPACE);
          send_byte(CH_SPACE);
          send_byte(word_byte());
        end
        send_byte(CH_LF);
      end
      FK_EMPTY_PREFIX: begin
        send_byte(CH_COLON);
        send_byte(CH_SPACE);
        send_byte(letter());
        send_byte(CH_LF);
      end
      default: begin
        send_byte(letter());
        send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        send_byte(CH_CR);
      end
    endcase
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fixed opening lines under the reset limits.
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    send_lines(380);

    // Walk through limit settings: both minimums, saturating values, the maximums.
    run_phase(13'd1, 4'd1, 150);
    run_phase(13'd8191, 4'd0, 300);
    run_phase(13'd0, 4'd15, 100);
    run_phase(13'd24, 4'd3, 200);

    // Hold the receiver off while bytes keep coming so the block backs up,
    // then pause the sender until everything has drained.
    hold_results = 1'b1;
    send_lines(80);
    drain();

    set_limits(13'd4096, 4'd2);
    send_lines(300);

    // Last part: no idling on either side, then one broken line and noise.
    run_phase(13'd20, 4'd15, 0);
    allow_gaps = 1'b0;
    send_lines(300);
    break_line(fault_kind_t'($urandom_range(0, 5)));
    repeat (40) send_byte(8'($urandom_range(0, 255)));

    drain();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("PASS irc_line_tokenizer");
    end else begin
      $display("FAIL irc_line_tokenizer");
    end
    $finish;
  end

  // Hard stop in case a handshake hangs.
  initial begin : watchdog
    #5ms;
    $display("FAIL irc_line_tokenizer");
    $finish;
  end

endmodule

[filelist.f]
src/irclt_pkg.sv
src/irclt_core.sv
src/irc_line_tokenizer.sv
bench/tb_irc_line_tokenizer.sv
